FILE: hw/rtl/skf_pkg.sv
`timescale 1ns / 1ps
// skf_pkg: shared types, constants and a saturation helper for the scalar
// Kalman filter bank. No dependencies.
package skf_pkg;

  localparam int KGAIN_BITS = 30;
  localparam int DIV_STAGES = KGAIN_BITS;

  localparam logic [47:0] MAX48  = 48'hFFFF_FFFF_FFFF;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic signed [63:0] HALF_Q30 = 64'sh2000_0000;

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_MEASURE = 1'b1;

  // one pipeline stage; each stage fills in the fields it owns
  typedef struct packed {
    logic               valid;
    logic               bypass;
    logic [5:0]         mode;
    logic signed [31:0] z;
    logic signed [31:0] a;
    logic [31:0]        aabs;
    logic signed [31:0] x;
    logic [47:0]        pc;
    logic [47:0]        w;
    logic [47:0]        v;
    logic signed [63:0] ax;
    logic [55:0]        m1lo;
    logic [55:0]        m1hi;
    logic signed [31:0] xp;
    logic [79:0]        ap;
    logic signed [32:0] d;
    logic [58:0]        p0;
    logic [58:0]        p1;
    logic [57:0]        p2;
    logic [111:0]       aap;
    logic [47:0]        pp;
    logic [48:0]        s;
    logic [48:0]        r;
    logic [KGAIN_BITS-1:0] k;
    logic signed [63:0] kd;
    logic [54:0]        nlo;
    logic [54:0]        nhi;
    logic signed [31:0] xn;
    logic [47:0]        pn;
    logic signed [63:0] pr;
  } skf_stage_t;

  // saturate a signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] res;
    if (v > 40'sh00_7FFF_FFFF)       res = 32'sh7FFF_FFFF;
    else if (v < -40'sh00_8000_0000) res = -32'sh8000_0000;
    else                             res = v[31:0];
    return res;
  endfunction

endpackage

FILE: hw/rtl/per_mode_scalar_kalman_filter.sv
`timescale 1ns / 1ps
// Bank of per-mode scalar AR(1) Kalman filters, one pipelined datapath.
// Depends on skf_pkg.
//
// One word per cycle in unless the output stalls or the word's mode is
// busy, one result per measure word out. The depth is set by the 30-stage
// restoring divider that forms the gain, one quotient bit per stage. A word
// whose mode still has a measurement in the pipeline waits until that
// measurement has written its estimate back; a load word also waits while
// a write-back takes the table port. Loads write the tables on acceptance
// and give no result. A mode with zero measurement variance, or beyond
// MODE_COUNT, echoes the measurement with bypassed set.
module per_mode_scalar_kalman_filter
  import skf_pkg::*;
#(
  parameter int MODE_COUNT = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_action,
  input  logic [5:0]         in_mode_index,
  input  logic signed [31:0] in_measurement,
  input  logic signed [31:0] in_decay_coefficient,
  input  logic [47:0]        in_process_variance,
  input  logic [47:0]        in_noise_variance,
  input  logic signed [31:0] in_initial_estimate,
  input  logic [47:0]        in_initial_covariance,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         out_result_mode,
  output logic signed [31:0] out_filtered_value,
  output logic signed [31:0] out_predicted_value,
  output logic               out_bypassed
);

  localparam int AW     = (MODE_COUNT > 1) ? $clog2(MODE_COUNT) : 1;
  localparam int S_MEM  = 1;
  localparam int S_XP   = 2;
  localparam int S_PART = 3;
  localparam int S_SUM  = 4;
  localparam int S_PP   = 5;
  localparam int S_DSET = 6;
  localparam int S_DIV  = 7;
  localparam int S_CORR = S_DIV + DIV_STAGES;
  localparam int S_UPD  = S_CORR + 1;
  localparam int S_PRED = S_UPD + 1;
  localparam int NS     = S_PRED + 1;

  // per-mode tables
  logic signed [31:0] coef_mem [MODE_COUNT];
  logic [47:0]        w_mem    [MODE_COUNT];
  logic [47:0]        v_mem    [MODE_COUNT];
  logic signed [31:0] x_mem    [MODE_COUNT];
  logic [47:0]        p_mem    [MODE_COUNT];

  logic signed [31:0] rd_a_r;
  logic [47:0]        rd_w_r;
  logic [47:0]        rd_v_r;
  logic signed [31:0] rd_x_r;
  logic [47:0]        rd_p_r;

  skf_stage_t st_r   [NS];
  skf_stage_t st_nxt [NS];

  logic               out_valid_r;
  logic [5:0]         out_mode_r;
  logic signed [31:0] out_filt_r;
  logic signed [31:0] out_pred_r;
  logic               out_byp_r;

  logic               adv;
  logic               busy;
  logic               acc;
  logic               in_range;
  logic               load_we;
  logic               wb_en;
  logic [AW-1:0]      in_addr;
  logic [AW-1:0]      wb_addr;

  // stage temporaries
  logic signed [63:0] t_ax;
  logic [111:0]       t_aap;
  logic [51:0]        t_hi;
  logic [47:0]        t_ppr;
  logic [48:0]        t_ppw;
  logic [49:0]        t_r2;
  logic [49:0]        t_s2;
  logic [30:0]        t_kg;
  logic signed [63:0] t_kd;
  logic [78:0]        t_ns;
  logic [48:0]        t_q;
  logic signed [63:0] t_pr;
  logic signed [31:0] pred_sat;

  // handshake and hazard control
  assign adv      = !out_valid_r || out_ready;
  assign in_range = 32'(in_mode_index) < MODE_COUNT;
  assign in_addr  = AW'(in_mode_index);
  assign wb_addr  = AW'(st_r[NS-1].mode);
  assign wb_en    = adv && st_r[NS-1].valid && !st_r[NS-1].bypass;

  always_comb begin
    busy = 1'b0;
    for (int i = 0; i < NS; i++) begin
      if (st_r[i].valid && (st_r[i].mode == in_mode_index)) busy = 1'b1;
    end
  end

  assign in_ready = adv && !busy && !((in_action == ACT_LOAD) && wb_en);
  assign acc      = in_valid && in_ready;
  assign load_we  = acc && (in_action == ACT_LOAD) && in_range;

  // tables: loads and write-backs never share a cycle
  always_ff @(posedge clk) begin
    if (load_we) begin
      coef_mem[in_addr] <= in_decay_coefficient;
      w_mem[in_addr]    <= in_process_variance;
      v_mem[in_addr]    <= in_noise_variance;
      x_mem[in_addr]    <= in_initial_estimate;
      p_mem[in_addr]    <= in_initial_covariance;
    end else if (wb_en) begin
      x_mem[wb_addr] <= st_r[NS-1].xn;
      p_mem[wb_addr] <= st_r[NS-1].pn;
    end
    if (acc) begin
      rd_a_r <= coef_mem[in_addr];
      rd_w_r <= w_mem[in_addr];
      rd_v_r <= v_mem[in_addr];
      rd_x_r <= x_mem[in_addr];
      rd_p_r <= p_mem[in_addr];
    end
  end

  // datapath stages
  always_comb begin
    t_ax = '0; t_aap = '0; t_hi = '0; t_ppr = '0; t_ppw = '0;
    t_r2 = '0; t_s2 = '0; t_kg = '0; t_kd = '0; t_ns = '0; t_q = '0;

    st_nxt[0]        = st_r[0];
    st_nxt[0].valid  = acc && (in_action == ACT_MEASURE);
    st_nxt[0].bypass = !in_range;
    st_nxt[0].mode   = in_mode_index;
    st_nxt[0].z      = in_measurement;
    for (int i = 1; i < NS; i++) st_nxt[i] = st_r[i-1];

    // table data; a*x and |a|*P partials
    st_nxt[S_MEM].bypass = st_r[S_MEM-1].bypass || (rd_v_r == '0);
    st_nxt[S_MEM].a      = rd_a_r;
    st_nxt[S_MEM].aabs   = rd_a_r[31] ? 32'(-rd_a_r) : 32'(rd_a_r);
    st_nxt[S_MEM].x      = rd_x_r;
    st_nxt[S_MEM].pc     = rd_p_r;
    st_nxt[S_MEM].w      = rd_w_r;
    st_nxt[S_MEM].v      = rd_v_r;
    st_nxt[S_MEM].ax     = 64'(rd_a_r) * 64'(rd_x_r);
    st_nxt[S_MEM].m1lo   = 56'(st_nxt[S_MEM].aabs) * 56'(rd_p_r[23:0]);
    st_nxt[S_MEM].m1hi   = 56'(st_nxt[S_MEM].aabs) * 56'(rd_p_r[47:24]);

    // prediction xp, |a|*P assembled
    t_ax = st_r[S_XP-1].ax + HALF_Q30;
    st_nxt[S_XP].xp = sat32(40'(t_ax >>> 30));
    st_nxt[S_XP].ap = 80'(st_r[S_XP-1].m1lo) + (80'(st_r[S_XP-1].m1hi) << 24);

    // innovation and a*a*P partials
    st_nxt[S_PART].d  = 33'(st_r[S_PART-1].z) - 33'(st_r[S_PART-1].xp);
    st_nxt[S_PART].p0 = 59'(st_r[S_PART-1].aabs) * 59'(st_r[S_PART-1].ap[26:0]);
    st_nxt[S_PART].p1 = 59'(st_r[S_PART-1].aabs) * 59'(st_r[S_PART-1].ap[53:27]);
    st_nxt[S_PART].p2 = 58'(st_r[S_PART-1].aabs) * 58'(st_r[S_PART-1].ap[79:54]);

    st_nxt[S_SUM].aap = 112'(st_r[S_SUM-1].p0) + (112'(st_r[S_SUM-1].p1) << 27)
                      + (112'(st_r[S_SUM-1].p2) << 54);

    // Pp = sat(round(a*a*P) + w)
    t_aap = st_r[S_PP-1].aap + (112'(1) << 59);
    t_hi  = t_aap[111:60];
    t_ppr = (t_hi > 52'(MAX48)) ? MAX48 : t_hi[47:0];
    t_ppw = 49'(t_ppr) + 49'(st_r[S_PP-1].w);
    st_nxt[S_PP].pp = t_ppw[48] ? MAX48 : t_ppw[47:0];

    // divider set-up: Pp / (Pp + v)
    st_nxt[S_DSET].s = 49'(st_r[S_DSET-1].pp) + 49'(st_r[S_DSET-1].v);
    st_nxt[S_DSET].r = 49'(st_r[S_DSET-1].pp);
    st_nxt[S_DSET].k = '0;

    // restoring division, one gain bit per stage
    for (int i = 0; i < DIV_STAGES; i++) begin
      t_r2 = {st_r[S_DIV+i-1].r, 1'b0};
      t_s2 = {1'b0, st_r[S_DIV+i-1].s};
      if (t_r2 >= t_s2) begin
        st_nxt[S_DIV+i].r = 49'(t_r2 - t_s2);
        st_nxt[S_DIV+i].k = {st_r[S_DIV+i-1].k[KGAIN_BITS-2:0], 1'b1};
      end else begin
        st_nxt[S_DIV+i].r = t_r2[48:0];
        st_nxt[S_DIV+i].k = {st_r[S_DIV+i-1].k[KGAIN_BITS-2:0], 1'b0};
      end
    end

    // K*(z-xp) and (1-K)*Pp partials
    t_kg = ONE_Q30 - {1'b0, st_r[S_CORR-1].k};
    st_nxt[S_CORR].kd  = 64'($signed({1'b0, st_r[S_CORR-1].k})) * 64'(st_r[S_CORR-1].d);
    st_nxt[S_CORR].nlo = 55'(t_kg) * 55'(st_r[S_CORR-1].pp[23:0]);
    st_nxt[S_CORR].nhi = 55'(t_kg) * 55'(st_r[S_CORR-1].pp[47:24]);

    // corrected estimate and covariance
    t_kd = st_r[S_UPD-1].kd + HALF_Q30;
    st_nxt[S_UPD].xn = sat32(40'(st_r[S_UPD-1].xp) + 40'(t_kd >>> 30));
    t_ns = 79'(st_r[S_UPD-1].nlo) + (79'(st_r[S_UPD-1].nhi) << 24) + (79'(1) << 29);
    t_q  = t_ns[78:30];
    st_nxt[S_UPD].pn = t_q[48] ? MAX48 : t_q[47:0];

    // next prediction a*xn
    st_nxt[S_PRED].pr = 64'(st_r[S_PRED-1].a) * 64'(st_r[S_PRED-1].xn);
  end

  // final rounding of the prediction
  always_comb begin
    t_pr     = st_r[NS-1].pr + HALF_Q30;
    pred_sat = sat32(40'(t_pr >>> 30));
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NS; i++) st_r[i].valid <= 1'b0;
    end else if (adv) begin
      for (int i = 0; i < NS; i++) st_r[i] <= st_nxt[i];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= st_r[NS-1].valid;
    end
    if (adv) begin
      out_mode_r <= st_r[NS-1].mode;
      out_byp_r  <= st_r[NS-1].bypass;
      out_filt_r <= st_r[NS-1].bypass ? st_r[NS-1].z : st_r[NS-1].xn;
      out_pred_r <= st_r[NS-1].bypass ? st_r[NS-1].z : pred_sat;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_mode     = out_mode_r;
  assign out_filtered_value  = out_filt_r;
  assign out_predicted_value = out_pred_r;
  assign out_bypassed        = out_byp_r;

  // checks
  a_no_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(load_we && wb_en))
    else $error("load and write-back in the same cycle");

  a_no_raw_hazard: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && st_r[NS-1].valid) |-> (in_mode_index != st_r[NS-1].mode))
    else $error("word accepted while its mode is in flight");

  a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r[NS-1].valid))
    else $error("result without a finished measure word");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(st_r[NS-1].valid) && $stable(st_r[0].valid))
    else $error("pipeline moved while stalled");

endmodule

FILE: test/tb_per_mode_scalar_kalman_filter.sv
`timescale 1ns / 1ps
// Testbench for per_mode_scalar_kalman_filter: directed and random load and
// measure words, checked against a bit-exact predictor kept in the bench.
// Depends on skf_pkg and the filter RTL.
module tb_per_mode_scalar_kalman_filter;
  import skf_pkg::*;

  typedef struct {
    logic               action;
    logic [5:0]         mode;
    logic signed [31:0] z;
    logic signed [31:0] a;
    logic [47:0]        w;
    logic [47:0]        v;
    logic signed [31:0] x0;
    logic [47:0]        p0;
  } word_t;

  typedef struct {
    logic [5:0]         mode;
    logic signed [31:0] filt;
    logic signed [31:0] pred;
    logic               byp;
  } filt_res_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_action = 1'b0;
  logic [5:0]         in_mode_index = '0;
  logic signed [31:0] in_measurement = '0;
  logic signed [31:0] in_decay_coefficient = '0;
  logic [47:0]        in_process_variance = '0;
  logic [47:0]        in_noise_variance = '0;
  logic signed [31:0] in_initial_estimate = '0;
  logic [47:0]        in_initial_covariance = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [5:0]         out_result_mode;
  logic signed [31:0] out_filtered_value;
  logic signed [31:0] out_predicted_value;
  logic               out_bypassed;

  per_mode_scalar_kalman_filter i_dut (.*);

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state per mode
  logic signed [31:0] est_mem [64];
  logic [47:0]        cov_mem [64];
  logic signed [31:0] coef_mem [64];
  logic [47:0]        wvar_mem [64];
  logic [47:0]        vvar_mem [64];

  word_t     pending_words [$];
  filt_res_t expected_results [$];
  word_t     cur;
  int        send_idle = 0;
  int        recv_idle = 0;
  int        errors = 0;
  int        n_loads = 0;
  int        n_measures = 0;
  int        n_bypassed = 0;
  int        n_checked = 0;

  function automatic logic signed [31:0] sat32s(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -128'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [47:0] sat48u(input logic signed [127:0] v);
    if (v > 128'sh FFFF_FFFF_FFFF) return MAX48;
    return v[47:0];
  endfunction

  // round to nearest with halves upward, then arithmetic shift
  function automatic logic signed [127:0] round_sh(input logic signed [127:0] v,
                                                   input int sh);
    logic signed [127:0] half;
    half = 128'sd1 <<< (sh - 1);
    return (v + half) >>> sh;
  endfunction

  // one filter step for an accepted word
  task automatic kalman_step(input word_t wd);
    logic signed [127:0] a, x, aa, pp, xp, xn, dz;
    logic [50:0]         s, r;
    logic [29:0]         k;
    filt_res_t           res;
    if (wd.action == ACT_LOAD) begin
      coef_mem[wd.mode] = wd.a;
      wvar_mem[wd.mode] = wd.w;
      vvar_mem[wd.mode] = wd.v;
      est_mem[wd.mode]  = wd.x0;
      cov_mem[wd.mode]  = wd.p0;
      n_loads++;
      return;
    end
    n_measures++;
    res.mode = wd.mode;
    if (vvar_mem[wd.mode] == 48'd0) begin
      res.filt = wd.z;
      res.pred = wd.z;
      res.byp  = 1'b1;
      n_bypassed++;
    end else begin
      a  = coef_mem[wd.mode];
      x  = est_mem[wd.mode];
      xp = sat32s(round_sh(a * x, 30));
      aa = (a < 0) ? -a : a;
      pp = sat48u(round_sh(aa * aa * $signed({80'd0, cov_mem[wd.mode]}), 60));
      pp = sat48u(pp + $signed({80'd0, wvar_mem[wd.mode]}));
      s  = pp[50:0] + {3'd0, vvar_mem[wd.mode]};
      r  = pp[50:0];
      k  = '0;
      for (int i = 0; i < 30; i++) begin
        r = r << 1;
        k = k << 1;
        if (r >= s) begin
          r = r - s;
          k[0] = 1'b1;
        end
      end
      dz = $signed({{96{wd.z[31]}}, wd.z}) - xp;
      xn = sat32s(xp + round_sh($signed({98'd0, k}) * dz, 30));
      est_mem[wd.mode] = xn[31:0];
      cov_mem[wd.mode] = sat48u(round_sh(
          ($signed(128'd1 << 30) - $signed({98'd0, k})) * pp, 30));
      res.filt = xn[31:0];
      res.pred = sat32s(round_sh(a * xn, 30));
      res.byp  = 1'b0;
    end
    expected_results.push_back(res);
  endtask

  // driver: predicts on acceptance, then offers the next word or idles
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) kalman_step(cur);
      if (pending_words.size() > 0 && $urandom_range(99) >= send_idle) begin
        cur = pending_words.pop_front();
        in_valid              <= 1'b1;
        in_action             <= cur.action;
        in_mode_index         <= cur.mode;
        in_measurement        <= cur.z;
        in_decay_coefficient  <= cur.a;
        in_process_variance   <= cur.w;
        in_noise_variance     <= cur.v;
        in_initial_estimate   <= cur.x0;
        in_initial_covariance <= cur.p0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: result words against the oldest expectation
  always @(posedge clk) begin
    filt_res_t e;
    if (rst_n) begin
      out_ready <= ($urandom_range(99) >= recv_idle);
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected (mode %0d)", out_result_mode);
          errors++;
        end else begin
          e = expected_results.pop_front();
          n_checked++;
          if (out_result_mode !== e.mode) begin
            $error("result_mode exp %0d got %0d", e.mode, out_result_mode);
            errors++;
          end
          if (out_filtered_value !== e.filt) begin
            $error("filtered_value exp %0d got %0d", e.filt, out_filtered_value);
            errors++;
          end
          if (out_predicted_value !== e.pred) begin
            $error("predicted_value exp %0d got %0d", e.pred, out_predicted_value);
            errors++;
          end
          if (out_bypassed !== e.byp) begin
            $error("bypassed exp %0b got %0b", e.byp, out_bypassed);
            errors++;
          end
        end
      end
    end
  end

  // random values with a random magnitude so small and large both occur
  function automatic logic [47:0] rnd48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0] >> $urandom_range(47, 0);
  endfunction

  function automatic logic signed [31:0] rnd32s();
    logic [31:0] r;
    r = $urandom >> $urandom_range(31, 0);
    if ($urandom_range(1)) r = ~r;
    return r;
  endfunction

  function automatic word_t load_word(input logic [5:0] m, input logic signed [31:0] a,
                                      input logic [47:0] w, input logic [47:0] v,
                                      input logic signed [31:0] x0,
                                      input logic [47:0] p0);
    word_t wd;
    wd.action = ACT_LOAD; wd.mode = m; wd.z = $urandom;
    wd.a = a; wd.w = w; wd.v = v; wd.x0 = x0; wd.p0 = p0;
    return wd;
  endfunction

  function automatic word_t meas_word(input logic [5:0] m, input logic signed [31:0] z);
    word_t wd;
    wd.action = ACT_MEASURE; wd.mode = m; wd.z = z;
    wd.a = $urandom; wd.w = rnd48(); wd.v = rnd48(); wd.x0 = $urandom; wd.p0 = rnd48();
    return wd;
  endfunction

  // hold off until the queue is empty and every result has come
  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  logic [5:0] loaded [$];

  task automatic random_phase(input int n);
    word_t      wd;
    logic [5:0] m;
    logic       wide;
    for (int i = 0; i < n; i++) begin
      wide = ($urandom_range(3) == 0);
      if ($urandom_range(99) < 15 || loaded.size() == 0) begin
        m = wide ? 6'($urandom) : 6'($urandom_range(7));
        wd = load_word(m,
                       ($urandom_range(4) == 0) ? $signed($urandom) : rnd32s() >>> 1,
                       rnd48(), ($urandom_range(9) == 0) ? 48'd0 : rnd48(),
                       ($urandom_range(4) == 0) ? $signed($urandom) : rnd32s(),
                       rnd48());
        loaded.push_back(m);
      end else begin
        m = loaded[$urandom_range(loaded.size() - 1)];
        wd = meas_word(m, ($urandom_range(4) == 0) ? $signed($urandom) : rnd32s());
      end
      pending_words.push_back(wd);
    end
  endtask

  // stimulus
  initial begin
    int guard;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, bypass, stable and unstable coefficients
    send_idle = 8; recv_idle = 62;
    pending_words.push_back(load_word(0, 32'sh8000_0000, MAX48, 48'd1,
                                      32'sh7FFF_FFFF, MAX48));
    pending_words.push_back(meas_word(0, 32'sh8000_0000));
    pending_words.push_back(meas_word(0, 32'sh7FFF_FFFF));
    pending_words.push_back(meas_word(0, 32'sh0));
    pending_words.push_back(load_word(1, 32'sh4000_0000, 48'd0, MAX48,
                                      32'sh8000_0000, 48'd0));
    pending_words.push_back(meas_word(1, 32'sh7FFF_FFFF));
    pending_words.push_back(meas_word(1, 32'sh8000_0000));
    pending_words.push_back(load_word(63, 32'sh7FFF_FFFF, 48'd1, 48'd0,
                                      32'sh1234_5678, MAX48));
    pending_words.push_back(meas_word(63, 32'sh8000_0000));
    pending_words.push_back(meas_word(63, 32'sh7FFF_FFFF));
    pending_words.push_back(load_word(2, 32'sh0, MAX48, 48'd1, 32'sh0, 48'd1));
    pending_words.push_back(meas_word(2, 32'sh7FFF_FFFF));
    pending_words.push_back(meas_word(2, -32'sd1));
    pending_words.push_back(load_word(3, 32'shC000_0000, 48'h100_0000_0000,
                                      48'h100_0000_0000, -32'sd1,
                                      48'h100_0000_0000));
    pending_words.push_back(meas_word(3, 32'sh1000_0000));
    pending_words.push_back(meas_word(3, 32'sh1000_0000));
    pending_words.push_back(meas_word(0, 32'sh1));
    pending_words.push_back(meas_word(1, 32'sh1));
    loaded = '{0, 1, 2, 3, 63};
    drain();

    // random, three idling regimes; the drains are full pauses by the sender
    random_phase(530);
    drain();
    send_idle = 62; recv_idle = 8;
    random_phase(530);
    drain();
    send_idle = 0; recv_idle = 0;
    random_phase(530);
    drain();
    guard = 0;
    while (guard < 60) begin
      @(posedge clk);
      guard++;
    end

    $display("covered %0d loads and %0d measures, %0d of them bypassed",
             n_loads, n_measures, n_bypassed);
    $display("%0d result words checked, %0d mismatches", n_checked, errors);
    if (errors == 0 && expected_results.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // watchdog
  initial begin
    #40ms;
    $display("tb: failure");
    $finish;
  end

endmodule
